/* rtl/rew_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rew_pkg: shared types and constants for the remote encoder waveform block
// Holds the payload structs of both channels, the configuration set and the
// register index codes of the configuration port.
// ----------------------------------------------------------------------------
package rew_pkg;

	localparam int ADDR_W     = 8;
	localparam int CMD_W      = 4;
	localparam int CMD_SLOTS  = 3;
	localparam int SPT_W      = 10;
	localparam int LEVEL_W    = 8;
	localparam int GAP_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_TICK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_SAMPLES      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FOREVER   = 3'd4;

	// Request kinds.
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] address;
		logic [1:0]        cmd_count;
		logic [CMD_W-1:0]  cmd_first;
		logic [CMD_W-1:0]  cmd_second;
		logic [CMD_W-1:0]  cmd_third;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] sample;
		logic               active;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [SPT_W-1:0]   samples_per_tick;
		logic [LEVEL_W-1:0] high_level;
		logic               invert;
		logic [GAP_W-1:0]   gap_samples;
		logic               repeat_forever;
	} cfg_t;

endpackage

/* rtl/rew_level.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rew_level: frame level decoder
// Maps the tick position inside a frame to the output level: preamble low,
// sync high, then three ticks per data bit (low, inverted bit, high).
// ----------------------------------------------------------------------------
module rew_level import rew_pkg::*; #(
	parameter int PREAMBLE_TICKS = 36,
	parameter int ADDRESS_BITS   = 8,
	parameter int TW             = 7
) (
	input  logic [TW-1:0]      tick,
	input  logic [ADDR_W-1:0]  address,
	input  logic [CMD_W-1:0]   cmd,
	input  logic               invert,
	input  logic [LEVEL_W-1:0] high_level,
	output logic [LEVEL_W-1:0] level
);

	localparam logic [TW-1:0] SYNC_TICK = TW'(PREAMBLE_TICKS);
	localparam logic [TW-1:0] BIT_BASE  = TW'(PREAMBLE_TICKS + 1);
	localparam logic [TW-1:0] ADDR_END  = TW'(ADDRESS_BITS);

	logic [TW-1:0]   off;
	logic [TW+7:0]   prod;
	logic [TW-1:0]   bit_idx;
	logic [TW+1:0]   bit_x3;
	logic [1:0]      phase;
	logic [TW-1:0]   data_idx;
	logic            bitv;
	logic            hi;

	always_comb begin
		off      = tick - BIT_BASE;
		// Divide by three through a reciprocal; exact for offsets below 512.
		prod     = {8'd0, off} * (TW+8)'(171);
		bit_idx  = TW'(prod >> 9);
		bit_x3   = {1'b0, bit_idx, 1'b0} + {2'b00, bit_idx};
		phase    = 2'(off - TW'(bit_x3));
		data_idx = bit_idx - ADDR_END;

		bitv = 1'b0;
		if (bit_idx < ADDR_END) begin
			if (bit_idx < TW'(ADDR_W))
				bitv = address[bit_idx[2:0]];
		end else begin
			if (data_idx < TW'(CMD_W))
				bitv = cmd[data_idx[1:0]];
		end

		if (tick < SYNC_TICK) begin
			hi = 1'b0;
		end else if (tick == SYNC_TICK) begin
			hi = 1'b1;
		end else begin
			case (phase)
				2'd0:    hi = 1'b0;
				2'd1:    hi = ~bitv;
				default: hi = 1'b1;
			endcase
		end

		level = (hi ^ invert) ? high_level : '0;
	end

endmodule

/* rtl/rew_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rew_seq: transmission sequencer
// Holds the latched transmission and the sample, tick, frame, command and
// gap counters, and forms the result of the item in the input stage.
// ----------------------------------------------------------------------------
module rew_seq import rew_pkg::*; #(
	parameter int FRAME_REPEATS  = 4,
	parameter int PREAMBLE_TICKS = 36,
	parameter int ADDRESS_BITS   = 8,
	parameter int DATA_BITS      = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int FRAME_TICKS = PREAMBLE_TICKS + 1 + 3 * (ADDRESS_BITS + DATA_BITS);
	localparam int TW = $clog2(FRAME_TICKS + 1);
	localparam int RW = $clog2(FRAME_REPEATS + 1);

	logic [SPT_W-1:0]          sit_q, sit_d;
	logic [TW-1:0]             tick_q, tick_d;
	logic [RW-1:0]             rep_q, rep_d;
	logic [1:0]                cidx_q, cidx_d;
	logic [GAP_W-1:0]          gap_q, gap_d;
	logic                      in_gap_q, in_gap_d;
	logic                      running_q, running_d;
	logic [ADDR_W-1:0]         addr_q, addr_d;
	logic [CMD_SLOTS*CMD_W-1:0] cmds_q, cmds_d;
	logic [1:0]                count_q, count_d;

	logic [SPT_W-1:0] spt;
	logic [SPT_W:0]   sit_inc;
	logic [TW-1:0]    tick_inc;
	logic [RW-1:0]    rep_inc;
	logic [2:0]       cidx_inc;
	logic [GAP_W-1:0] gap_inc;
	logic [CMD_W-1:0] cmd_sel;
	logic [LEVEL_W-1:0] level;

	always_comb begin
		case (cidx_q)
			2'd0:    cmd_sel = cmds_q[CMD_W-1:0];
			2'd1:    cmd_sel = cmds_q[2*CMD_W-1:CMD_W];
			2'd2:    cmd_sel = cmds_q[3*CMD_W-1:2*CMD_W];
			default: cmd_sel = '0;
		endcase
	end

	rew_level #(
		.PREAMBLE_TICKS (PREAMBLE_TICKS),
		.ADDRESS_BITS   (ADDRESS_BITS),
		.TW             (TW)
	) u_level (
		.tick       (tick_q),
		.address    (addr_q),
		.cmd        (cmd_sel),
		.invert     (cfg.invert),
		.high_level (cfg.high_level),
		.level      (level)
	);

	always_comb begin
		sit_d     = sit_q;
		tick_d    = tick_q;
		rep_d     = rep_q;
		cidx_d    = cidx_q;
		gap_d     = gap_q;
		in_gap_d  = in_gap_q;
		running_d = running_q;
		addr_d    = addr_q;
		cmds_d    = cmds_q;
		count_d   = count_q;
		res       = '0;

		spt      = (cfg.samples_per_tick == '0) ? SPT_W'(1) : cfg.samples_per_tick;
		sit_inc  = {1'b0, sit_q} + (SPT_W+1)'(1);
		tick_inc = tick_q + TW'(1);
		rep_inc  = rep_q + RW'(1);
		cidx_inc = {1'b0, cidx_q} + 3'd1;
		gap_inc  = gap_q + GAP_W'(1);

		if (item.req_type == REQ_START) begin
			addr_d    = item.address;
			count_d   = (item.cmd_count == 2'd0) ? 2'd1 : item.cmd_count;
			cmds_d    = {item.cmd_third, item.cmd_second, item.cmd_first};
			sit_d     = '0;
			tick_d    = '0;
			rep_d     = '0;
			cidx_d    = '0;
			gap_d     = '0;
			in_gap_d  = 1'b0;
			running_d = 1'b1;
		end else if (running_q) begin
			res.active = 1'b1;
			if (in_gap_q) begin
				gap_d = gap_inc;
				if (gap_inc >= cfg.gap_samples) begin
					in_gap_d = 1'b0;
					gap_d    = '0;
				end
			end else begin
				res.sample = level;
				sit_d      = SPT_W'(sit_inc);
				if (sit_inc >= {1'b0, spt}) begin
					sit_d  = '0;
					tick_d = tick_inc;
					if (tick_inc >= TW'(FRAME_TICKS)) begin
						tick_d = '0;
						rep_d  = rep_inc;
						if (rep_inc >= RW'(FRAME_REPEATS)) begin
							rep_d = '0;
							if (cidx_inc < {1'b0, count_q}) begin
								cidx_d   = 2'(cidx_inc);
								gap_d    = '0;
								in_gap_d = (cfg.gap_samples != '0);
							end else begin
								res.last = 1'b1;
								cidx_d   = '0;
								if (!cfg.repeat_forever)
									running_d = 1'b0;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sit_q     <= '0;
			tick_q    <= '0;
			rep_q     <= '0;
			cidx_q    <= '0;
			gap_q     <= '0;
			in_gap_q  <= 1'b0;
			running_q <= 1'b0;
			addr_q    <= '0;
			cmds_q    <= '0;
			count_q   <= 2'd1;
		end else if (adv) begin
			sit_q     <= sit_d;
			tick_q    <= tick_d;
			rep_q     <= rep_d;
			cidx_q    <= cidx_d;
			gap_q     <= gap_d;
			in_gap_q  <= in_gap_d;
			running_q <= running_d;
			addr_q    <= addr_d;
			cmds_q    <= cmds_d;
			count_q   <= count_d;
		end
	end

endmodule

/* rtl/remote_encoder_waveform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_encoder_waveform: remote control encoder sample generator
// Produces the sampled waveform of an encoded remote control transmission.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid, item_stall, item): a start beat latches the
//   address and up to three commands and restarts the transmission; a sample
//   beat asks for the next sample. Every item beat yields one result beat.
//   result channel (result_valid, result_stall, result): sample level, an
//   active flag and a last flag on the final sample of a pass.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no beat is in flight.
// An accepted item beat passes through the input register, then the sequencer
// step into the result register. Throughput is one beat per cycle while the
// result side does not stall, limited by the single state update of the
// sequencer per beat.
// A stall on the result side holds the result register; the input register
// then holds too and item_stall rises in the same cycle. Reset empties both
// registers, stops any transmission and loads the register defaults.
// ----------------------------------------------------------------------------
module remote_encoder_waveform import rew_pkg::*; #(
	parameter int FRAME_REPEATS  = 4,
	parameter int PREAMBLE_TICKS = 36,
	parameter int ADDRESS_BITS   = 8,
	parameter int DATA_BITS      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	logic    accept;
	result_t res;
	result_t result_q;
	logic    result_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_tick <= SPT_W'(16);
			cfg_q.high_level       <= LEVEL_W'(255);
			cfg_q.invert           <= 1'b0;
			cfg_q.gap_samples      <= GAP_W'(768000);
			cfg_q.repeat_forever   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLES_PER_TICK: cfg_q.samples_per_tick <= cfg_data[SPT_W-1:0];
				CFG_HIGH_LEVEL:       cfg_q.high_level       <= cfg_data[LEVEL_W-1:0];
				CFG_INVERT:           cfg_q.invert           <= cfg_data[0];
				CFG_GAP_SAMPLES:      cfg_q.gap_samples      <= cfg_data[GAP_W-1:0];
				CFG_REPEAT_FOREVER:   cfg_q.repeat_forever   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The input stage moves on whenever the result register is free or drains.
	assign adv        = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	rew_seq #(
		.FRAME_REPEATS  (FRAME_REPEATS),
		.PREAMBLE_TICKS (PREAMBLE_TICKS),
		.ADDRESS_BITS   (ADDRESS_BITS),
		.DATA_BITS      (DATA_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_last_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.last || result.active))
		else $error("last flag set on an inactive sample");

	a_idle_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.active) |-> (result.sample == '0))
		else $error("nonzero sample while inactive");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("item stalled without a blocked result");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid_q)
		else $error("advanced beat did not reach the result register");

endmodule
